// ----- hw/rtl/stxf_pkg.sv -----
package stxf_pkg;

   localparam logic [7:0] STX_CHAR = 8'h02;
   localparam logic [7:0] ETX_CHAR = 8'h03;
   localparam logic [7:0] CR_CHAR = 8'h0D;
   localparam logic [7:0] LF_CHAR = 8'h0A;
   localparam logic [7:0] BCC_MASK = 8'h03;
   localparam logic [7:0] ZERO_CHAR = 8'h30;
   localparam logic [7:0] UPPER_A_CHAR = 8'h41;
   localparam logic [3:0] TEN_NIB = 4'd10;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   typedef enum logic [6:0] {
      PH_STX  = 7'b0000001,
      PH_DATA = 7'b0000010,
      PH_ETX  = 7'b0000100,
      PH_HI   = 7'b0001000,
      PH_LO   = 7'b0010000,
      PH_CR   = 7'b0100000,
      PH_LF   = 7'b1000000
   } phase_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < TEN_NIB) begin
         res = ZERO_CHAR + {4'd0, nib};
      end else begin
         res = UPPER_A_CHAR + {4'd0, nib - TEN_NIB};
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/stxf_seq.sv -----
module stxf_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stxf_pkg::req_type req_data,
   output logic              byte_valid,
   input  logic              byte_ready,
   output stxf_pkg::rsp_type byte_data
);

   stxf_pkg::req_type   item_ff, item_in;
   logic                item_vld_ff, item_vld_in;
   stxf_pkg::phase_type phase_ff, phase_in;
   logic                inside_ff, inside_in;
   logic [7:0]          accum_ff, accum_in;
   logic [7:0]          bcc;
   logic                adv;
   logic                done;
   logic                accept;

   assign bcc = accum_ff ^ stxf_pkg::BCC_MASK;
   assign byte_valid = item_vld_ff;
   assign adv = item_vld_ff && byte_ready;
   assign req_ready = !item_vld_ff || done;
   assign accept = req_valid && req_ready;

   always_comb begin
      byte_data = '0;
      done = 1'b0;
      phase_in = phase_ff;
      inside_in = inside_ff;
      accum_in = accum_ff;
      case (phase_ff)
         stxf_pkg::PH_STX: begin
            byte_data.out_byte = stxf_pkg::STX_CHAR;
            if (adv) begin
               phase_in = stxf_pkg::PH_DATA;
               inside_in = 1'b1;
            end
         end
         stxf_pkg::PH_DATA: begin
            byte_data.out_byte = item_ff.payload_byte;
            if (adv) begin
               accum_in = accum_ff ^ item_ff.payload_byte;
               if (item_ff.frame_end) begin
                  phase_in = stxf_pkg::PH_ETX;
               end else begin
                  done = 1'b1;
               end
            end
         end
         stxf_pkg::PH_ETX: begin
            byte_data.out_byte = stxf_pkg::ETX_CHAR;
            if (adv) begin
               phase_in = stxf_pkg::PH_HI;
            end
         end
         stxf_pkg::PH_HI: begin
            byte_data.out_byte = stxf_pkg::hex_digit(bcc[7:4]);
            if (adv) begin
               phase_in = stxf_pkg::PH_LO;
            end
         end
         stxf_pkg::PH_LO: begin
            byte_data.out_byte = stxf_pkg::hex_digit(bcc[3:0]);
            if (adv) begin
               phase_in = stxf_pkg::PH_CR;
            end
         end
         stxf_pkg::PH_CR: begin
            byte_data.out_byte = stxf_pkg::CR_CHAR;
            if (adv) begin
               phase_in = stxf_pkg::PH_LF;
            end
         end
         stxf_pkg::PH_LF: begin
            byte_data.out_byte = stxf_pkg::LF_CHAR;
            byte_data.out_last = 1'b1;
            if (adv) begin
               done = 1'b1;
               inside_in = 1'b0;
               accum_in = '0;
            end
         end
         default: begin
            byte_data = '0;
         end
      endcase
      item_in = item_ff;
      item_vld_in = item_vld_ff && !done;
      if (accept) begin
         item_in = req_data;
         item_vld_in = 1'b1;
         phase_in = inside_in ? stxf_pkg::PH_DATA : stxf_pkg::PH_STX;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         item_vld_ff <= 1'b0;
         phase_ff <= stxf_pkg::PH_STX;
         inside_ff <= 1'b0;
         accum_ff <= '0;
      end else begin
         item_vld_ff <= item_vld_in;
         phase_ff <= phase_in;
         inside_ff <= inside_in;
         accum_ff <= accum_in;
      end
   end

endmodule

// ----- hw/rtl/stx_etx_xor_bcc_framer_top.sv -----
// channel   direction  item
// req_      in         payload_byte, frame_end
// rsp_      out        out_byte, out_last
//
// one output byte per cycle while the receiver is ready; an item gives 1 byte, 2 with STX, 6 or 7 with the trailer
// the byte sequencer steps once per output byte and holds the item while the trailer goes out
// the result register takes a new byte whenever it is empty or being drained
// reset clears the frame state and drops both valids

module stx_etx_xor_bcc_framer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stxf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stxf_pkg::rsp_type rsp_data
);

   logic              byte_valid;
   logic              byte_ready;
   stxf_pkg::rsp_type byte_data;
   logic              rsp_vld_ff, rsp_vld_in;
   stxf_pkg::rsp_type rsp_data_ff;

   stxf_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .byte_valid (byte_valid),
      .byte_ready (byte_ready),
      .byte_data  (byte_data)
   );

   assign byte_ready = !rsp_vld_ff || rsp_ready;
   assign rsp_vld_in = byte_valid || (rsp_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (byte_valid && byte_ready) begin
         rsp_data_ff <= byte_data;
      end
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data = rsp_data_ff;

   a_last_is_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_last |-> rsp_data.out_byte == stxf_pkg::LF_CHAR)
      else $error("last byte is not LF");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_held_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled byte changed");

endmodule

// ----- bench/stx_etx_xor_bcc_framer_top_test.sv -----
module stx_etx_xor_bcc_framer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 300;
   localparam int DRAIN_CYCLES = 24;
   localparam int QUIET_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_START = 250;
   localparam int HOLD_STOP = 450;
   localparam int RSP_CALM_START = 550;
   localparam int RSP_CALM_STOP = 900;
   localparam int REQ_CALM_START = 100;
   localparam int REQ_CALM_STOP = 180;
   localparam int NUM_ROWS = 23;

   typedef struct packed {
      logic [7:0]  pbyte;
      logic        fend;
      logic [3:0]  n_typed;
      logic [55:0] typed;
   } dir_row_type;

   // typed bytes are packed from the top, n_typed of 0 means use the predictor
   localparam dir_row_type DIR_ROWS [0:NUM_ROWS-1] = '{
      '{8'h41, 1'b0, 4'd2, 56'h02_41_00_00_00_00_00},
      '{8'h42, 1'b1, 4'd0, 56'h0},
      '{8'h00, 1'b1, 4'd7, 56'h02_00_03_30_33_0D_0A},
      '{8'hFF, 1'b1, 4'd7, 56'h02_FF_03_46_43_0D_0A},
      '{8'h03, 1'b1, 4'd7, 56'h02_03_03_30_30_0D_0A},
      '{8'hFC, 1'b1, 4'd7, 56'h02_FC_03_46_46_0D_0A},
      '{8'hF9, 1'b1, 4'd7, 56'h02_F9_03_46_41_0D_0A},
      '{8'h0C, 1'b1, 4'd7, 56'h02_0C_03_30_46_0D_0A},
      '{8'hA3, 1'b1, 4'd7, 56'h02_A3_03_41_30_0D_0A},
      '{8'h80, 1'b0, 4'd0, 56'h0},
      '{8'h7F, 1'b0, 4'd0, 56'h0},
      '{8'h55, 1'b0, 4'd0, 56'h0},
      '{8'hAA, 1'b1, 4'd0, 56'h0},
      '{8'h01, 1'b0, 4'd0, 56'h0},
      '{8'h02, 1'b0, 4'd0, 56'h0},
      '{8'h04, 1'b0, 4'd0, 56'h0},
      '{8'h08, 1'b0, 4'd0, 56'h0},
      '{8'h10, 1'b0, 4'd0, 56'h0},
      '{8'h20, 1'b0, 4'd0, 56'h0},
      '{8'h40, 1'b0, 4'd0, 56'h0},
      '{8'h80, 1'b1, 4'd0, 56'h0},
      '{8'hE5, 1'b0, 4'd0, 56'h0},
      '{8'h9C, 1'b1, 4'd0, 56'h0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   stxf_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   stxf_pkg::rsp_type rsp_data;

   stxf_pkg::rsp_type framed_q [$];
   bit         in_frame = 1'b0;
   logic [7:0] xor_sum = 8'h00;
   int errors = 0;
   int items_sent = 0;
   int bytes_seen = 0;
   int frames_seen = 0;
   int quiet = 0;

   stx_etx_xor_bcc_framer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] nib_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return stxf_pkg::ZERO_CHAR + {4'd0, nib};
      end
      return stxf_pkg::UPPER_A_CHAR + {4'd0, nib} - 8'd10;
   endfunction

   function automatic int frame_predict(input stxf_pkg::req_type it,
                                        output stxf_pkg::rsp_type seq [7]);
      int n;
      logic [7:0] bcc;
      n = 0;
      for (int k = 0; k < 7; k++) begin
         seq[k] = '0;
      end
      if (!in_frame) begin
         seq[n] = '{out_byte: stxf_pkg::STX_CHAR, out_last: 1'b0};
         n++;
         in_frame = 1'b1;
         xor_sum = 8'h00;
      end
      seq[n] = '{out_byte: it.payload_byte, out_last: 1'b0};
      n++;
      xor_sum = xor_sum ^ it.payload_byte;
      if (it.frame_end) begin
         bcc = xor_sum ^ stxf_pkg::BCC_MASK;
         seq[n] = '{out_byte: stxf_pkg::ETX_CHAR, out_last: 1'b0};
         seq[n+1] = '{out_byte: nib_char(bcc[7:4]), out_last: 1'b0};
         seq[n+2] = '{out_byte: nib_char(bcc[3:0]), out_last: 1'b0};
         seq[n+3] = '{out_byte: stxf_pkg::CR_CHAR, out_last: 1'b0};
         seq[n+4] = '{out_byte: stxf_pkg::LF_CHAR, out_last: 1'b1};
         n += 5;
         in_frame = 1'b0;
         xor_sum = 8'h00;
      end
      return n;
   endfunction

   task automatic note_error(input string msg);
      errors++;
      if (errors <= REPORT_LIMIT) begin
         $display("mismatch: %s", msg);
      end
   endtask

   task automatic push_item(input stxf_pkg::req_type it, input int n_typed,
                            input logic [55:0] typed);
      stxf_pkg::rsp_type seq [7];
      stxf_pkg::rsp_type want;
      int n;
      int gap;
      bit calm;
      calm = items_sent >= NUM_ROWS + REQ_CALM_START && items_sent < NUM_ROWS + REQ_CALM_STOP;
      gap = 0;
      if (!calm && $urandom_range(99) < 9) begin
         gap = $urandom_range(4, 1);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      n = frame_predict(it, seq);
      if (n_typed > 0) begin
         for (int k = 0; k < n_typed; k++) begin
            want.out_byte = typed[55 - 8*k -: 8];
            want.out_last = (k == n_typed - 1) && it.frame_end;
            framed_q.push_back(want);
         end
      end else begin
         for (int k = 0; k < n; k++) begin
            framed_q.push_back(seq[k]);
         end
      end
   endtask

   initial begin
      stxf_pkg::req_type it;
      int len;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int r = 0; r < NUM_ROWS; r++) begin
         it.payload_byte = DIR_ROWS[r].pbyte;
         it.frame_end = DIR_ROWS[r].fend;
         push_item(it, DIR_ROWS[r].n_typed, DIR_ROWS[r].typed);
      end
      while (items_sent < NUM_ROWS + RANDOM_ITEMS) begin
         if ($urandom_range(8) == 0) begin
            len = $urandom_range(24, 8);
         end else begin
            len = $urandom_range(5, 1);
         end
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(3) == 0) begin
               it.payload_byte = 8'($urandom_range(255));
            end else begin
               it.payload_byte = 8'($urandom_range(8'h7E, 8'h20));
            end
            it.frame_end = (i == len - 1);
            push_item(it, 0, 56'h0);
         end
      end
      req_valid <= 1'b0;
      while (framed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (framed_q.size() != 0) begin
         note_error($sformatf("%0d framed bytes never arrived", framed_q.size()));
      end
      $display("sent %0d payload items, checked %0d framed bytes in %0d frames",
               items_sent, bytes_seen, frames_seen);
      $display("covered one-byte frames, long frames, high-bit bytes and output hold-off");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // receiver with random stalls, one long hold-off and a stall-free stretch
   initial begin
      int cyc;
      cyc = 0;
      while (reset) @(posedge clock);
      forever begin
         cyc++;
         if (cyc >= HOLD_START && cyc < HOLD_STOP) begin
            rsp_ready <= 1'b0;
         end else if (cyc >= RSP_CALM_START && cyc < RSP_CALM_STOP) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 9);
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_out
      stxf_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         bytes_seen++;
         if (rsp_data.out_last) begin
            frames_seen++;
         end
         if (framed_q.size() == 0) begin
            note_error($sformatf("unexpected byte %02h last %0b",
                                 rsp_data.out_byte, rsp_data.out_last));
         end else begin
            want = framed_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               note_error($sformatf("byte %0d out_byte expected %02h got %02h",
                                    bytes_seen, want.out_byte, rsp_data.out_byte));
            end
            if (rsp_data.out_last !== want.out_last) begin
               note_error($sformatf("byte %0d out_last expected %0b got %0b",
                                    bytes_seen, want.out_last, rsp_data.out_last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
         $display("timeout with %0d framed bytes outstanding", framed_q.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
